// ===== rtl/core/uer_pkg.sv =====
package uer_pkg;

  // Field widths of the input and result transactions.
  localparam int unsigned TICK_W = 16;
  localparam int unsigned TRIG_W = 8;
  localparam int unsigned MS_W   = 10;
  localparam int unsigned DIST_W = 10;
  localparam int unsigned ECHO_W = 15;
  localparam int unsigned CFG_W  = 16;

  // Timer ticks per centimetre of range.
  localparam int unsigned TICKS_PER_CM = 116;

  // Reciprocal for the divide by TICKS_PER_CM on a TICK_W-bit count.
  localparam int unsigned DIV_SHIFT = TICK_W + $clog2(TICKS_PER_CM);
  localparam int unsigned DIV_RECIP = (2**DIV_SHIFT + TICKS_PER_CM - 1) / TICKS_PER_CM;
  localparam int unsigned PROD_W    = TICK_W + DIV_SHIFT;

  // Reset values of the configuration registers and the period counter.
  localparam logic [TRIG_W-1:0] TRIG_TICKS_RST    = 8'd20;
  localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 16'd60000;
  localparam logic [MS_W-1:0]   MIN_PERIOD_RST    = 10'd250;
  localparam logic [DIST_W-1:0] MAX_DIST_RST      = 10'd0;
  localparam logic [DIST_W-1:0] DIST_SAT          = 10'd1023;

  // Configuration register indexes.
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_TRIG_TICKS    = 2'd0;
  localparam cfg_idx_t CFG_TIMEOUT_TICKS = 2'd1;
  localparam cfg_idx_t CFG_MIN_PERIOD_MS = 2'd2;
  localparam cfg_idx_t CFG_MAX_DIST_CM   = 2'd3;

  typedef struct packed {
    logic [TRIG_W-1:0] trig_ticks;
    logic [TICK_W-1:0] timeout_ticks;
    logic [MS_W-1:0]   min_period_ms;
    logic [DIST_W-1:0] range_limit_cm;
  } cfg_regs_t;

  typedef struct packed {
    logic echo;
    logic start_req;
    logic ms_tick;
    logic read_ack;
  } in_item_t;

  typedef struct packed {
    logic              trig;
    logic              busy_res;
    logic              ready_res;
    logic              error;
    logic              object_detected;
    logic [DIST_W-1:0] obj_range_cm;
    logic [ECHO_W-1:0] pulse_us;
  } out_item_t;

endpackage

// ===== rtl/core/ultrasonic_echo_ranger.sv =====
// Flow: a transaction accepted into the input register moves into the output
// register when the phase update advances it; an output stall holds it in between.
// Throughput: one tick transaction per cycle while the output is not stalled; the single
// phase update between the input and result registers sets that figure.
// Reset (rst_n, synchronous, active low): idle phase, results and flags clear,
// configuration at its defaults, and the period counter full so a first start is taken.
module ultrasonic_echo_ranger (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  uer_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output uer_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  uer_pkg::cfg_idx_t         cfg_idx,
  input  logic [uer_pkg::CFG_W-1:0] cfg_wdata
);

  uer_pkg::cfg_regs_t cfg_regs;
  uer_pkg::in_item_t  in_r;
  logic               in_valid_r;
  logic               adv;
  logic               in_take;

  uer_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg_regs  (cfg_regs)
  );

  // The held transaction moves on whenever the result register is free or draining.
  assign adv      = in_valid_r && (!out_valid || !out_stall);
  assign in_stall = in_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
  end

  uer_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_regs  (cfg_regs),
    .adv       (adv),
    .item      (in_r),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/uer_cfg.sv =====
module uer_cfg (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  uer_pkg::cfg_idx_t        cfg_idx,
  input  logic [uer_pkg::CFG_W-1:0] cfg_wdata,
  output uer_pkg::cfg_regs_t       cfg_regs
);

  uer_pkg::cfg_regs_t regs_r;
  uer_pkg::cfg_regs_t regs_nxt;

  // Decode the register index and take the low bits of the write data.
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      case (cfg_idx)
        uer_pkg::CFG_TRIG_TICKS:    regs_nxt.trig_ticks = cfg_wdata[uer_pkg::TRIG_W-1:0];
        uer_pkg::CFG_TIMEOUT_TICKS: regs_nxt.timeout_ticks = cfg_wdata[uer_pkg::TICK_W-1:0];
        uer_pkg::CFG_MIN_PERIOD_MS: regs_nxt.min_period_ms = cfg_wdata[uer_pkg::MS_W-1:0];
        uer_pkg::CFG_MAX_DIST_CM:   regs_nxt.range_limit_cm = cfg_wdata[uer_pkg::DIST_W-1:0];
        default: regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.trig_ticks     <= uer_pkg::TRIG_TICKS_RST;
      regs_r.timeout_ticks  <= uer_pkg::TIMEOUT_TICKS_RST;
      regs_r.min_period_ms  <= uer_pkg::MIN_PERIOD_RST;
      regs_r.range_limit_cm <= uer_pkg::MAX_DIST_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign cfg_regs = regs_r;

endmodule

// ===== rtl/core/uer_div.sv =====
module uer_div (
  input  logic [uer_pkg::TICK_W-1:0] ticks,
  output logic [uer_pkg::DIST_W-1:0] obj_range_cm,
  output logic [uer_pkg::ECHO_W-1:0] pulse_us
);

  logic [uer_pkg::PROD_W-1:0] prod;
  logic [uer_pkg::TICK_W-1:0] quot;

  // Divide by the ticks-per-centimetre constant through its rounded-up reciprocal;
  // the shift is wide enough that the quotient is exact over the whole count range.
  assign prod = uer_pkg::PROD_W'(ticks) * uer_pkg::PROD_W'(uer_pkg::DIV_RECIP);
  assign quot = prod[uer_pkg::PROD_W-1:uer_pkg::DIV_SHIFT];

  // Clamp the distance to its field range.
  assign obj_range_cm = (quot > uer_pkg::TICK_W'(uer_pkg::DIST_SAT)) ?
                        uer_pkg::DIST_SAT : quot[uer_pkg::DIST_W-1:0];

  // Two ticks make one microsecond.
  assign pulse_us = ticks[uer_pkg::TICK_W-1:1];

endmodule

// ===== rtl/core/uer_seq.sv =====
module uer_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  uer_pkg::cfg_regs_t cfg_regs,
  input  logic               adv,
  input  uer_pkg::in_item_t  item,
  input  logic               out_stall,
  output logic               out_valid,
  output uer_pkg::out_item_t out_data
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG,
    PH_WAIT_HIGH,
    PH_WAIT_LOW
  } phase_t;

  phase_t                     phase_r, phase_nxt;
  logic [uer_pkg::TICK_W-1:0] tick_r, tick_nxt;
  logic [uer_pkg::MS_W-1:0]   period_r, period_nxt;
  logic [uer_pkg::DIST_W-1:0] dist_r, dist_nxt;
  logic [uer_pkg::ECHO_W-1:0] echo_us_r, echo_us_nxt;
  logic                       ready_r, ready_nxt;
  logic                       error_r, error_nxt;
  logic                       object_r, object_nxt;
  logic                       trig_nxt;
  logic                       res_valid_r;
  uer_pkg::out_item_t         res_r;

  logic [uer_pkg::TICK_W-1:0] tick_sat_inc;
  logic [uer_pkg::DIST_W-1:0] div_dist;
  logic [uer_pkg::ECHO_W-1:0] div_echo_us;

  // The saturating count also feeds the divider when the echo falls.
  assign tick_sat_inc = (tick_r == '1) ? tick_r : tick_r + 1'b1;

  uer_div u_div (
    .ticks        (tick_sat_inc),
    .obj_range_cm (div_dist),
    .pulse_us     (div_echo_us)
  );

  // One tick of the measurement sequence.
  always_comb begin
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    period_nxt  = period_r;
    dist_nxt    = dist_r;
    echo_us_nxt = echo_us_r;
    ready_nxt   = ready_r & ~item.read_ack;
    error_nxt   = error_r;
    object_nxt  = object_r;
    trig_nxt    = 1'b0;

    case (phase_r)
      PH_IDLE: begin
        if (item.start_req && (period_r >= cfg_regs.min_period_ms)) begin
          dist_nxt    = '0;
          echo_us_nxt = '0;
          ready_nxt   = 1'b0;
          error_nxt   = 1'b0;
          object_nxt  = 1'b0;
          period_nxt  = '0;
          tick_nxt    = '0;
          phase_nxt   = PH_TRIG;
          trig_nxt    = 1'b1;
        end
      end
      PH_TRIG: begin
        if ((tick_r + 1'b1) >= uer_pkg::TICK_W'(cfg_regs.trig_ticks)) begin
          phase_nxt = PH_WAIT_HIGH;
          tick_nxt  = '0;
        end else begin
          tick_nxt = tick_r + 1'b1;
          trig_nxt = 1'b1;
        end
      end
      PH_WAIT_HIGH: begin
        if (item.echo) begin
          phase_nxt = PH_WAIT_LOW;
          tick_nxt  = '0;
        end else if (tick_sat_inc >= cfg_regs.timeout_ticks) begin
          error_nxt = 1'b1;
          phase_nxt = PH_IDLE;
          tick_nxt  = '0;
        end else begin
          tick_nxt = tick_sat_inc;
        end
      end
      PH_WAIT_LOW: begin
        if (!item.echo) begin
          dist_nxt    = div_dist;
          echo_us_nxt = div_echo_us;
          object_nxt  = (cfg_regs.range_limit_cm != '0) &&
                        (div_dist <= cfg_regs.range_limit_cm);
          ready_nxt   = 1'b1;
          phase_nxt   = PH_IDLE;
          tick_nxt    = '0;
        end else if (tick_sat_inc >= cfg_regs.timeout_ticks) begin
          error_nxt = 1'b1;
          phase_nxt = PH_IDLE;
          tick_nxt  = '0;
        end else begin
          tick_nxt = tick_sat_inc;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        tick_nxt  = '0;
      end
    endcase

    // The millisecond count runs after any start on the same tick.
    if (item.ms_tick && (period_nxt < cfg_regs.min_period_ms)) begin
      period_nxt = period_nxt + 1'b1;
    end
  end

  // State and result register, advanced once per transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      period_r    <= uer_pkg::MIN_PERIOD_RST;
      dist_r      <= '0;
      echo_us_r   <= '0;
      ready_r     <= 1'b0;
      error_r     <= 1'b0;
      object_r    <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        phase_r                <= phase_nxt;
        tick_r                 <= tick_nxt;
        period_r               <= period_nxt;
        dist_r                 <= dist_nxt;
        echo_us_r              <= echo_us_nxt;
        ready_r                <= ready_nxt;
        error_r                <= error_nxt;
        object_r               <= object_nxt;
        res_valid_r            <= 1'b1;
        res_r.trig             <= trig_nxt;
        res_r.busy_res         <= (phase_nxt != PH_IDLE);
        res_r.ready_res        <= ready_nxt;
        res_r.error            <= error_nxt;
        res_r.object_detected  <= object_nxt;
        res_r.obj_range_cm     <= dist_nxt;
        res_r.pulse_us         <= echo_us_nxt;
      end else if (!out_stall) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = res_valid_r;
  assign out_data  = res_r;

  // A trigger pulse only appears while a measurement is in progress.
  a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.trig |-> res_r.busy_res)
    else $error("trig driven while not busy");

  // A measurement ends either with a result or with a timeout, never both.
  a_ready_error: assert property (@(posedge clk) disable iff (!rst_n)
    !(ready_r && error_r))
    else $error("ready and error set together");

  // The idle phase always leaves the tick counter cleared.
  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> tick_r == '0)
    else $error("tick counter not cleared in idle");

  // Without a new transaction a stalled result must not move.
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && out_stall && !adv |=> res_valid_r && $stable(res_r))
    else $error("stalled result changed");

endmodule

// ===== dv/uer_tb_pkg.sv =====
package uer_tb_pkg;

  import uer_pkg::*;

  // Measurement phases of the ranger.
  typedef enum int {RNG_IDLE, RNG_TRIGGER, RNG_WAIT_RISE, RNG_WAIT_FALL} rng_phase_t;

  // Predicts the status report for every accepted tick and compares it with the
  // reports that the block delivers, oldest first.
  class ranger_scoreboard;
    cfg_regs_t   regs;
    rng_phase_t  ph;
    int unsigned ticks;
    int unsigned ms_count;
    logic [DIST_W-1:0] range_q;
    logic [ECHO_W-1:0] echo_us;
    bit          ready;
    bit          err;
    bit          obj;
    out_item_t   expected_reports[$];
    int          mismatches;
    int          checked;

    function new();
      regs.trig_ticks     = TRIG_TICKS_RST;
      regs.timeout_ticks  = TIMEOUT_TICKS_RST;
      regs.min_period_ms  = MIN_PERIOD_RST;
      regs.range_limit_cm = MAX_DIST_RST;
      ph         = RNG_IDLE;
      ticks      = 0;
      ms_count   = MIN_PERIOD_RST;
      range_q    = '0;
      echo_us    = '0;
      ready      = 1'b0;
      err        = 1'b0;
      obj        = 1'b0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_TRIG_TICKS:    regs.trig_ticks     = val[TRIG_W-1:0];
        CFG_TIMEOUT_TICKS: regs.timeout_ticks  = val[TICK_W-1:0];
        CFG_MIN_PERIOD_MS: regs.min_period_ms  = val[MS_W-1:0];
        CFG_MAX_DIST_CM:   regs.range_limit_cm = val[DIST_W-1:0];
        default: ;
      endcase
    endfunction

    // Either echo wait ran out of time: flag the error and go back to idle.
    function void abort_timeout();
      err   = 1'b1;
      ph    = RNG_IDLE;
      ticks = 0;
    endfunction

    // Advance the prediction by one accepted tick and queue the report it gives.
    function void note_tick(in_item_t it);
      out_item_t   want;
      bit          trig;
      int unsigned d;
      trig = 1'b0;
      if (it.read_ack) begin
        ready = 1'b0;
      end
      case (ph)
        RNG_IDLE: begin
          if (it.start_req && ms_count >= regs.min_period_ms) begin
            range_q  = '0;
            echo_us  = '0;
            ready    = 1'b0;
            err      = 1'b0;
            obj      = 1'b0;
            ms_count = 0;
            ticks    = 0;
            ph       = RNG_TRIGGER;
            trig     = 1'b1;
          end
        end
        RNG_TRIGGER: begin
          ticks = (ticks + 1) & 32'hFFFF;
          if (ticks >= regs.trig_ticks) begin
            ph    = RNG_WAIT_RISE;
            ticks = 0;
          end else begin
            trig = 1'b1;
          end
        end
        RNG_WAIT_RISE: begin
          if (it.echo) begin
            ph    = RNG_WAIT_FALL;
            ticks = 0;
          end else begin
            if (ticks < 32'hFFFF) ticks++;
            if (ticks >= regs.timeout_ticks) abort_timeout();
          end
        end
        RNG_WAIT_FALL: begin
          if (ticks < 32'hFFFF) ticks++;
          if (!it.echo) begin
            // Echo has fallen: convert the pulse width into time and range.
            d = ticks / TICKS_PER_CM;
            if (d > DIST_SAT) d = DIST_SAT;
            range_q = DIST_W'(d);
            echo_us = ECHO_W'(ticks >> 1);
            obj     = (regs.range_limit_cm != 0) && (d <= regs.range_limit_cm);
            ready   = 1'b1;
            ph      = RNG_IDLE;
            ticks   = 0;
          end else if (ticks >= regs.timeout_ticks) begin
            abort_timeout();
          end
        end
        default: begin
          ph    = RNG_IDLE;
          ticks = 0;
        end
      endcase
      if (it.ms_tick && ms_count < regs.min_period_ms) begin
        ms_count++;
      end
      want.trig            = trig;
      want.busy_res        = (ph != RNG_IDLE);
      want.ready_res       = ready;
      want.error           = err;
      want.object_detected = obj;
      want.obj_range_cm    = range_q;
      want.pulse_us        = echo_us;
      expected_reports.push_back(want);
    endfunction

    // Compare one delivered report with the oldest prediction.
    function void check_report(out_item_t got);
      out_item_t want;
      bit        bad;
      checked++;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("report %0d arrived with nothing expected: %p", checked, got);
        end
        return;
      end
      want = expected_reports.pop_front();
      bad = (got.trig !== want.trig) || (got.busy_res !== want.busy_res) ||
            (got.ready_res !== want.ready_res) || (got.error !== want.error) ||
            (got.object_detected !== want.object_detected) ||
            (got.obj_range_cm !== want.obj_range_cm) ||
            (got.pulse_us !== want.pulse_us);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("report %0d exp: trig %b busy %b rdy %b err %b obj %b cm %0d us %0d",
                   checked, want.trig, want.busy_res, want.ready_res, want.error,
                   want.object_detected, want.obj_range_cm, want.pulse_us);
          $display("report %0d act: trig %b busy %b rdy %b err %b obj %b cm %0d us %0d",
                   checked, got.trig, got.busy_res, got.ready_res, got.error,
                   got.object_detected, got.obj_range_cm, got.pulse_us);
        end
      end
    endfunction
  endclass

endpackage

// ===== dv/tb_top.sv =====
module tb_top;

  import uer_pkg::*;
  import uer_tb_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int PHASE_TICKS  = 280;
  localparam int PRESSURE_AT  = 500;
  localparam int PRESSURE_LEN = 300;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_we = 1'b0;
  cfg_idx_t          cfg_idx = CFG_TRIG_TICKS;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  ranger_scoreboard sb = new();
  int ticks_sent = 0;
  int tx_burst = 0;
  int rx_burst = 0;
  int quiet_cycles = 0;
  bit rx_hold = 1'b0;
  bit rx_hold_done = 1'b0;

  // Register settings of the random phases: trigger length, timeout, period, range.
  int phase_cfg [7][4] = '{
    '{1,   1,     0,    1023},
    '{255, 65535, 0,    0},
    '{20,  300,   3,    2},
    '{5,   2000,  1,    10},
    '{3,   200,   1023, 1},
    '{20,  60000, 250,  0},
    '{2,   150,   0,    1}
  };

  ultrasonic_echo_ranger DUT (.*);

  always #5 clk = ~clk;

  // Idle cycles before the next transaction, with occasional runs of none at all.
  function automatic int draw_wait(ref int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic in_item_t pin(bit echo, bit start, bit ms, bit ack);
    in_item_t it;
    it.echo      = echo;
    it.start_req = start;
    it.ms_tick   = ms;
    it.read_ack  = ack;
    return it;
  endfunction

  // A tick with the given echo and start, and random millisecond strobe and read.
  function automatic in_item_t tick_item(bit echo, bit start);
    return pin(echo, start, $urandom_range(0, 2) == 0, $urandom_range(0, 7) == 0);
  endfunction

  // Offer one tick transaction and hold it until the block takes it.
  task automatic send_tick(in_item_t it);
    int gap;
    gap = rx_hold ? 0 : draw_wait(tx_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_tick(it);
    ticks_sent++;
  endtask

  // Let every outstanding report arrive, then write all four registers.
  task automatic write_regs(int trig_len, int tmo, int gap_ms, int range_cm);
    cfg_idx_t          idx_list [4];
    logic [CFG_W-1:0]  vals [4];
    idx_list = '{CFG_TRIG_TICKS, CFG_TIMEOUT_TICKS, CFG_MIN_PERIOD_MS, CFG_MAX_DIST_CM};
    vals     = '{CFG_W'(trig_len), CFG_W'(tmo), CFG_W'(gap_ms), CFG_W'(range_cm)};
    in_valid <= 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idx_list[i];
      cfg_wdata <= vals[i];
      sb.write_reg(idx_list[i], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // One well-formed measurement with random content: wait out the period, start,
  // ride the trigger pulse, then an echo whose timing lands near the limits often.
  task automatic ranging_cycle();
    int need;
    int tmo;
    int wait_len;
    int hold_len;
    tmo  = sb.regs.timeout_ticks;
    need = int'(sb.regs.min_period_ms) - int'(sb.ms_count);
    if (need > 0 && need <= 260) begin
      repeat (need) send_tick(pin($urandom_range(0, 1), 1'b0, 1'b1, $urandom_range(0, 7) == 0));
    end
    send_tick(tick_item($urandom_range(0, 1), 1'b1));
    // Echo during the trigger pulse is noise that the block must ignore.
    while (sb.ph == RNG_TRIGGER) begin
      send_tick(tick_item($urandom_range(0, 1), $urandom_range(0, 9) == 0));
    end
    if (sb.ph != RNG_WAIT_RISE) return;

    case ($urandom_range(0, 9))
      0, 1:    wait_len = tmo - 1;
      2:       wait_len = tmo;
      3:       wait_len = $urandom_range(0, (tmo > 400) ? 400 : tmo + 2);
      default: wait_len = $urandom_range(0, (tmo > 30) ? 30 : tmo);
    endcase
    if (wait_len > 400) wait_len = $urandom_range(0, 30);
    for (int i = 0; i < wait_len && sb.ph == RNG_WAIT_RISE; i++) begin
      send_tick(tick_item(1'b0, $urandom_range(0, 9) == 0));
    end
    if (sb.ph != RNG_WAIT_RISE) return;
    send_tick(tick_item(1'b1, $urandom_range(0, 9) == 0));

    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8: hold_len = $urandom_range(0, 40);
      9, 10, 11, 12, 13, 14:     hold_len = $urandom_range(100, 400);
      15, 16:                    hold_len = $urandom_range(400, 1500);
      default:                   hold_len = (tmo > 2) ? tmo - 2 + $urandom_range(0, 2) : tmo;
    endcase
    if (hold_len > 1500) hold_len = $urandom_range(0, 40);
    while (sb.ph == RNG_WAIT_FALL && sb.ticks < hold_len) begin
      send_tick(tick_item(1'b1, $urandom_range(0, 9) == 0));
    end
    if (sb.ph == RNG_WAIT_FALL) begin
      send_tick(tick_item(1'b0, $urandom_range(0, 9) == 0));
    end
    repeat ($urandom_range(0, 4)) send_tick(tick_item($urandom_range(0, 1), 1'b0));
  endtask

  // A short burst of fully random ticks.
  task automatic line_noise();
    repeat ($urandom_range(1, 12)) begin
      send_tick(pin($urandom_range(0, 1), $urandom_range(0, 1),
                    $urandom_range(0, 1), $urandom_range(0, 1)));
    end
  endtask

  // Stimulus: reset, directed ticks, then random phases under several settings.
  initial begin
    int stop_at;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Short trigger and timeout, two-millisecond period, detection disabled.
    write_regs(1, 4, 2, 0);
    send_tick(pin(0, 0, 0, 1));   // read with nothing waiting
    send_tick(pin(0, 1, 0, 0));   // first start taken on the full period count
    send_tick(pin(0, 1, 0, 0));   // start while busy is ignored
    repeat (4) send_tick(pin(0, 0, 0, 0));  // no echo: rise wait times out
    send_tick(pin(0, 1, 0, 0));   // too early after the last start
    send_tick(pin(0, 0, 1, 0));
    send_tick(pin(0, 1, 1, 0));   // still one millisecond short
    send_tick(pin(1, 1, 1, 0));   // taken; echo during the trigger is ignored
    send_tick(pin(0, 0, 1, 0));
    send_tick(pin(1, 0, 0, 0));   // echo rises
    send_tick(pin(0, 0, 0, 1));   // falls with a read on the same tick
    send_tick(pin(0, 0, 0, 1));   // read clears ready
    send_tick(pin(0, 1, 0, 0));
    repeat (6) send_tick(pin(1, 0, 0, 0));  // echo stays high: fall wait times out
    send_tick(pin(1, 1, 1, 1));

    for (int p = 0; p < 7; p++) begin
      write_regs(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
      stop_at = ticks_sent + PHASE_TICKS;
      while (ticks_sent < stop_at) begin
        if ($urandom_range(0, 9) < 8) ranging_cycle();
        else line_noise();
      end
    end

    in_valid <= 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.expected_reports.size() != 0) begin
      $display("%0d expected reports never arrived", sb.expected_reports.size());
    end
    if (sb.mismatches == 0 && sb.expected_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Report side: random stalls, plus one long hold-off that backs up the block.
  initial begin
    int n;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      n = draw_wait(rx_burst);
      if (!rx_hold_done && sb.checked >= PRESSURE_AT) begin
        rx_hold_done = 1'b1;
        rx_hold      = 1'b1;
        n            = PRESSURE_LEN;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rx_hold = 1'b0;
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_report(out_data);
    end
  end

  // Watchdog: too long without any transaction on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
rtl/core/uer_pkg.sv
rtl/core/uer_cfg.sv
rtl/core/uer_div.sv
rtl/core/uer_seq.sv
rtl/core/ultrasonic_echo_ranger.sv
dv/uer_tb_pkg.sv
dv/tb_top.sv
